// ----- hdl/gsr_pkg.sv -----
// Shared types, constants and threshold function for the graded speed ramp.
package gsr_pkg;

    localparam int SPEED_W    = 15;
    localparam int STEP_W     = 7;
    localparam int NUM_GRADES = 8;

    typedef logic [SPEED_W-1:0] speed_t;
    typedef logic [STEP_W-1:0]  step_t;

    // Grade k (index k-1) holds floor(full_scale * k / 10).
    typedef logic [NUM_GRADES-1:0][SPEED_W-1:0] thr_set_t;

    localparam speed_t FS_RESET = 15'd32767;

    // x / 10 == (x * 52429) >> 19, exact for x below 2^18.
    localparam int RECIP_10 = 52429;
    localparam int RECIP_SH = 19;
    localparam int PROD_W   = 34;

    localparam step_t STEP_MIN      = 7'd10;
    localparam step_t FALL_STEP_HI  = 7'd50;
    localparam step_t FALL_STEP_MID = 7'd35;
    localparam step_t FALL_STEP_LO  = 7'd20;
    localparam step_t STEP_MAX      = 7'd90;
    localparam int    FALL_HI_IDX   = 7;   // 0.8 of full scale
    localparam int    FALL_MID_IDX  = 2;   // 0.3 of full scale
    localparam int    SNAP_WINDOW   = 40;

    localparam step_t RISE_STEP_TAB [NUM_GRADES] =
        '{7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90};

    typedef struct packed {
        speed_t target_speed;
        speed_t filtered_speed;
        speed_t estimated_speed;
        logic   preload;
        speed_t preload_speed;
    } gsr_item_t;

    typedef struct packed {
        speed_t ramp;
        step_t  step;
    } gsr_res_t;

    function automatic thr_set_t thr_of(input speed_t fs);
        thr_set_t            thr;
        logic [PROD_W-1:0]   prod;
        for (int k = 0; k < NUM_GRADES; k++)
        begin
            prod   = {{(PROD_W-SPEED_W){1'b0}}, fs} * PROD_W'((k + 1) * RECIP_10);
            thr[k] = prod[RECIP_SH +: SPEED_W];
        end
        return thr;
    endfunction

endpackage

// ----- hdl/gsr_thresh.sv -----
// Full-scale register: holds the graded thresholds derived from each write.
module gsr_thresh
    import gsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  speed_t   cfg_data,
    output thr_set_t thr
);

    thr_set_t thr_reg;
    thr_set_t thr_next;

    always_comb
    begin
        thr_next = cfg_we ? thr_of(cfg_data) : thr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= thr_of(FS_RESET);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

// ----- hdl/gsr_step.sv -----
// Step selection and next ramp value for one tick.
module gsr_step
    import gsr_pkg::*;
(
    input  gsr_item_t item,
    input  speed_t    ramp,
    input  thr_set_t  thr,
    output gsr_res_t  res
);

    logic signed [SPEED_W:0] rise_gap;
    logic signed [SPEED_W:0] fall_gap;
    logic signed [SPEED_W:0] fall_diff;
    logic        [SPEED_W:0] rise_sum;
    step_t                   rise_step;
    step_t                   fall_step;

    assign rise_gap  = $signed({1'b0, item.target_speed}) - $signed({1'b0, item.estimated_speed});
    assign fall_gap  = $signed({1'b0, ramp}) - $signed({1'b0, item.target_speed});
    assign rise_sum  = {1'b0, ramp} + {{(SPEED_W+1-STEP_W){1'b0}}, rise_step};
    assign fall_diff = $signed({1'b0, ramp})
                     - $signed({{(SPEED_W+1-STEP_W){1'b0}}, fall_step});

    // thresholds are monotonic, so the last grade passed is the largest one
    always_comb
    begin
        rise_step = STEP_MIN;
        for (int k = 0; k < NUM_GRADES; k++)
        begin
            if (rise_gap > $signed({1'b0, thr[k]}))
            begin
                rise_step = RISE_STEP_TAB[k];
            end
        end
    end

    always_comb
    begin
        if (fall_gap > $signed({1'b0, thr[FALL_HI_IDX]}))
        begin
            fall_step = FALL_STEP_HI;
        end
        else if (fall_gap > $signed({1'b0, thr[FALL_MID_IDX]}))
        begin
            fall_step = FALL_STEP_MID;
        end
        else
        begin
            fall_step = FALL_STEP_LO;
        end
    end

    always_comb
    begin
        res = '{ramp: ramp, step: '0};
        if (item.preload)
        begin
            res.ramp = item.preload_speed;
        end
        else if (item.filtered_speed < item.target_speed)
        begin
            res.step = rise_step;
            if (rise_sum < {1'b0, item.target_speed})
            begin
                res.ramp = rise_sum[SPEED_W-1:0];
            end
            else if (-fall_gap < (SPEED_W+1)'(SNAP_WINDOW))
            begin
                // close enough (or already above): snap to target
                res.ramp = item.target_speed;
            end
        end
        else
        begin
            res.step = fall_step;
            if (fall_diff > $signed({1'b0, item.target_speed})
                && {1'b0, ramp} > {{(SPEED_W+1-STEP_W){1'b0}}, fall_step})
            begin
                res.ramp = fall_diff[SPEED_W-1:0];
            end
            else
            begin
                res.ramp = item.target_speed;
            end
        end
    end

endmodule

// ----- hdl/graded_speed_ramp.sv -----
// Graded speed reference ramp generator: top level with input and result stages.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one ramp tick per beat: target,
//   filtered and estimated speeds, a preload flag and a preload speed.
//   Output channel (out_valid/out_ready) returns one beat per tick: the ramp
//   value after the tick and the step chosen (0 on preload).
//   cfg_we/cfg_data write the full-scale speed; the threshold set is derived
//   at the write edge, so a tick accepted on the next edge already uses it.
// Path: an accepted tick passes through one input register and one result
//   register before it is presented on the output.
// Throughput: one tick per cycle while out_ready holds; the ramp state loops
//   through the step logic between the input register and the ramp register.
// Reset: ramp clears to 0, full scale returns to 32767, both stages empty.
// Stall: while the output beat waits, one more tick is taken into the input
//   register; in_ready drops only when both stages are full.
module graded_speed_ramp
    import gsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  speed_t cfg_data,
    input  logic   in_valid,
    output logic   in_ready,
    input  speed_t target_speed,
    input  speed_t filtered_speed,
    input  speed_t estimated_speed,
    input  logic   preload,
    input  speed_t preload_speed,
    output logic   out_valid,
    input  logic   out_ready,
    output speed_t ramp_speed,
    output step_t  step_size
);

    thr_set_t  thr;
    gsr_item_t s1_item_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    speed_t    ramp_value_reg;
    step_t     step_size_reg;
    gsr_res_t  res;
    logic      adv;
    logic      take;

    gsr_thresh u_thresh (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .thr      (thr)
    );

    gsr_step u_step (
        .item (s1_item_reg),
        .ramp (ramp_value_reg),
        .thr  (thr),
        .res  (res)
    );

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = take || (s1_valid_reg && !adv);
        out_valid_next = adv || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ramp_value_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                ramp_value_reg <= res.ramp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= '{target_speed:    target_speed,
                             filtered_speed:  filtered_speed,
                             estimated_speed: estimated_speed,
                             preload:         preload,
                             preload_speed:   preload_speed};
        end
        if (adv)
        begin
            step_size_reg <= res.step;
        end
    end

    // the ramp register only moves with a new result, so it doubles as output
    assign out_valid  = out_valid_reg;
    assign ramp_speed = ramp_value_reg;
    assign step_size  = step_size_reg;

    a_preload_load: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_item_reg.preload
        |=> step_size_reg == '0 && ramp_value_reg == $past(s1_item_reg.preload_speed))
        else $error("preload tick did not load the ramp");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("held tick lost from input stage");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> step_size_reg <= STEP_MAX)
        else $error("step out of range");

    a_ramp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(ramp_value_reg))
        else $error("ramp moved without a tick");

endmodule
